[rtl/core/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] value;
		logic        [7:0]  priority_req;
	} spq_in_t;

	typedef struct packed {
		logic signed [31:0] removed_value;
		logic        [1:0]  status;
		logic        [4:0]  occupancy;
	} spq_out_t;

	// one stored entry
	typedef struct packed {
		logic signed [31:0] value;
		logic        [7:0]  prio;
	} spq_entry_t;

	typedef enum logic [1:0] {
		SPQ_IDLE,
		SPQ_RD,
		SPQ_CHK,
		SPQ_FIN
	} spq_state_t;

endpackage

[rtl/core/sorted_priority_queue_core.sv]
// Entries read per word: insert reads each entry
// that moves back and, unless all of them move, the one that ends the scan; remove reads
// every held entry; insert on empty or full queue and remove on empty read none.
// Throughput: one word at a time; the read loop over the entry memory
// sets the rate. Reset: arst_n clears the count and control; memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept as a sorted array in one synchronous memory.
// Entries shift one slot per read/write step on insert and remove.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  spq_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output spq_out_t out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	// entry memory
	spq_entry_t mem [DEPTH];
	spq_entry_t rd_s1;

	spq_state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] idx_q, idx_d;
	spq_in_t req_q;
	logic signed [31:0] rem_q, rem_d;
	logic [1:0] st_q, st_d;
	spq_out_t out_q;
	logic out_valid_q;
	logic load_out;

	logic we;
	logic [AW-1:0] wa, ra;
	spq_entry_t wd;
	logic accept;
	logic last_rm;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == SPQ_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign last_rm   = ((CW'(idx_q) + CW'(1)) == cnt_q);

	// next state, memory port control
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		rem_d    = rem_q;
		st_d     = st_q;
		we       = 1'b0;
		wa       = idx_q;
		wd       = '{value: req_q.value, prio: req_q.priority_req};
		ra       = idx_q;
		load_out = 1'b0;
		case (state_q)
			SPQ_IDLE: begin
				if (accept) begin
					rem_d = '0;
					st_d  = ST_DONE;
					if (in_data.req_type == REQ_INSERT) begin
						if (cnt_q == CW'(DEPTH)) begin
							st_d    = ST_FULL;
							state_d = SPQ_FIN;
						end else if (cnt_q == '0) begin
							we      = 1'b1;
							wa      = '0;
							wd      = '{value: in_data.value, prio: in_data.priority_req};
							cnt_d   = CW'(1);
							state_d = SPQ_FIN;
						end else begin
							idx_d   = AW'(cnt_q - CW'(1));
							state_d = SPQ_RD;
						end
					end else begin
						if (cnt_q == '0) begin
							st_d    = ST_EMPTY;
							state_d = SPQ_FIN;
						end else begin
							idx_d   = '0;
							state_d = SPQ_RD;
						end
					end
				end
			end
			SPQ_RD: begin
				state_d = SPQ_CHK;
			end
			SPQ_CHK: begin
				if (req_q.req_type == REQ_INSERT) begin
					we = 1'b1;
					if (rd_s1.prio > req_q.priority_req) begin
						// move entry back one slot
						wa = idx_q + AW'(1);
						wd = rd_s1;
						if (idx_q == '0) begin
							state_d = SPQ_CHK;
							idx_d   = '0;
							// place new entry at head next
							state_d = SPQ_FIN;
						end else begin
							idx_d   = idx_q - AW'(1);
							state_d = SPQ_RD;
						end
					end else begin
						wa      = idx_q + AW'(1);
						cnt_d   = cnt_q + CW'(1);
						state_d = SPQ_FIN;
					end
				end else begin
					if (idx_q == '0) begin
						rem_d = rd_s1.value;
					end else begin
						we = 1'b1;
						wa = idx_q - AW'(1);
						wd = rd_s1;
					end
					if (last_rm) begin
						cnt_d   = cnt_q - CW'(1);
						state_d = SPQ_FIN;
					end else begin
						idx_d   = idx_q + AW'(1);
						state_d = SPQ_RD;
					end
				end
			end
			SPQ_FIN: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = SPQ_IDLE;
				end
			end
			default: begin
				state_d = SPQ_IDLE;
			end
		endcase
	end

	// head write left pending when every held entry moved back
	logic head_wr_q;

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (head_wr_q) begin
			mem[AW'(0)] <= '{value: req_q.value, prio: req_q.priority_req};
		end else if (we) begin
			mem[wa] <= wd;
		end
		rd_s1 <= mem[ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SPQ_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			head_wr_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_wr_q <= (state_q == SPQ_CHK) && (req_q.req_type == REQ_INSERT) &&
				(rd_s1.prio > req_q.priority_req) && (idx_q == '0);
			if ((state_q == SPQ_CHK) && (req_q.req_type == REQ_INSERT) &&
				(rd_s1.prio > req_q.priority_req) && (idx_q == '0)) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= cnt_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		rem_q <= rem_d;
		st_q  <= st_d;
		if (accept) begin
			req_q <= in_data;
		end
		if (load_out) begin
			out_q <= '{removed_value: rem_q, status: st_q, occupancy: 5'(cnt_q)};
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("result word dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != SPQ_IDLE))
		else $error("accepted word skipped processing");
`endif

endmodule

[bench/tb_sorted_priority_queue_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_core
// Drives insert and remove words into the queue core and checks every status
// word against a sorted-array model kept in the bench. Both handshakes see
// random idle bursts except in the closing stretch.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;
	import spq_pkg::*;

	localparam int QDEPTH = 16;
	localparam int STALL_LIMIT = 20000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	spq_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	spq_out_t out_data;

	// bench copy of the queue contents, head at index 0
	spq_entry_t held_q[$];
	spq_out_t   status_q[$];
	int         error_count;
	int         stall_cycles;
	int         words_sent;
	int         words_checked;
	int         full_drops;
	int         empty_removes;
	bit         idle_enable;

	sorted_priority_queue_core #(.DEPTH(QDEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one word to the queue model and return the expected status word
	function automatic spq_out_t queue_apply(spq_in_t w);
		spq_out_t   r;
		spq_entry_t e;
		int         pos;
		r = '0;
		if (w.req_type == REQ_INSERT) begin
			if (held_q.size() >= QDEPTH) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_q.size() && held_q[pos].prio <= w.priority_req)
					pos++;
				e.value = w.value;
				e.prio  = w.priority_req;
				held_q.insert(pos, e);
				r.status = ST_DONE;
			end
		end else begin
			if (held_q.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.removed_value = held_q[0].value;
				void'(held_q.pop_front());
				r.status = ST_DONE;
			end
		end
		r.occupancy = 5'(held_q.size());
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %0s: got %0h want %0h (word %0d)", what, got, want, words_checked);
		error_count++;
	endtask

	// send one word; optional idle burst first, valid stays up between words
	task automatic send_word(logic req, logic [31:0] val, logic [7:0] pri);
		spq_in_t w;
		int      gap;
		w.req_type     = req;
		w.value        = val;
		w.priority_req = pri;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		status_q.push_back(queue_apply(w));
		words_sent++;
		if (w.req_type == REQ_INSERT && status_q[$].status == ST_FULL)
			full_drops++;
		if (w.req_type == REQ_REMOVE && status_q[$].status == ST_EMPTY)
			empty_removes++;
	endtask

	// drop valid and wait for every outstanding status word
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		spq_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (status_q.size() == 0) begin
				report_mismatch("unexpected word", out_data.removed_value, 32'h0);
			end else begin
				want = status_q.pop_front();
				if (out_data.removed_value !== want.removed_value)
					report_mismatch("removed_value", out_data.removed_value,
						want.removed_value);
				if (out_data.status !== want.status)
					report_mismatch("status", 32'(out_data.status), 32'(want.status));
				if (out_data.occupancy !== want.occupancy)
					report_mismatch("occupancy", 32'(out_data.occupancy),
						32'(want.occupancy));
			end
			words_checked++;
		end
	end

	// output stall bursts
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (idle_enable && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				n = $urandom_range(1, 7);
			end else begin
				out_ready <= 1'b1;
				n = $urandom_range(1, 12);
			end
			repeat (n) @(posedge clk);
		end
	end

	// watchdog on cycles without a handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog expired");
			$display("tb: failure");
			$finish;
		end
	end

	// directed: empty remove, fill past full, extremes, ties, then drain
	task automatic test_directed();
		send_word(REQ_REMOVE, 32'h1234_5678, 8'hff);
		send_word(REQ_INSERT, 32'h8000_0000, 8'hff);
		send_word(REQ_INSERT, 32'h7fff_ffff, 8'h00);
		send_word(REQ_INSERT, 32'hffff_ffff, 8'h80);
		send_word(REQ_INSERT, 32'h0000_0000, 8'h80);
		for (int i = 0; i < 14; i++)
			send_word(REQ_INSERT, $urandom(), 8'(i % 3 == 0 ? 8'h80 : $urandom()));
		for (int i = 0; i < 18; i++)
			send_word(REQ_REMOVE, $urandom(), $urandom());
	endtask

	// random mix with phases biased toward fill, drain or balance
	task automatic test_random(int count, int pri_span);
		int bias;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0)
				bias = $urandom_range(20, 80);
			send_word($urandom_range(0, 99) < bias ? REQ_INSERT : REQ_REMOVE,
				$urandom(), 8'($urandom_range(0, pri_span)));
		end
	endtask

	// sender holds off until all status words are back, then sends 50 words with priorities 0 to 3
	task automatic test_drain_pause();
		wait_drained();
		repeat (20) @(posedge clk);
		test_random(50, 3);
	endtask

	initial begin
		error_count  = 0;
		stall_cycles = 0;
		words_sent   = 0;
		words_checked = 0;
		full_drops   = 0;
		empty_removes = 0;
		idle_enable  = 1'b1;
		in_valid     = 1'b0;
		in_data      = '0;
		arst_n       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(800, 255);
		test_drain_pause();
		test_random(700, 7);
		idle_enable = 1'b0;
		test_random(300, 255);

		wait_drained();
		repeat (100) @(posedge clk);
		$display("covered %0d words, %0d full drops, %0d removes on empty",
			words_sent, full_drops, empty_removes);
		if (error_count == 0 && status_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/spq_pkg.sv
rtl/core/sorted_priority_queue_core.sv
bench/tb_sorted_priority_queue_core.sv
